/* rtl/core/ham_enc_pkg.sv */
`default_nettype none

package ham_enc_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned DATA_BYTES   = 57;
    localparam int unsigned CODE_BYTES   = 63;
    localparam int unsigned CW_BITS      = 63;
    localparam int unsigned CW_DATA_BITS = 57;
    localparam int unsigned PARITY_BITS  = 6;

    // input bit accumulator: up to 56 held bits plus one byte
    localparam int unsigned ACC_W  = CW_DATA_BITS - 1 + BYTE_W;
    // output bit buffer: up to 7 leftover bits plus one codeword
    localparam int unsigned OBUF_W = CW_BITS + BYTE_W - 1;

    localparam int unsigned FILL_W = $clog2(DATA_BYTES);
    localparam int unsigned OCNT_W = $clog2(CODE_BYTES);
    localparam int unsigned ACNT_W = $clog2(ACC_W + 1);
    localparam int unsigned OBCW   = $clog2(OBUF_W + 1);

    typedef enum logic {
        PH_COLLECT,
        PH_ENCODE
    } phase_t;

    // Place data bits at the non power of two positions (1-based), then set
    // parity bit 2^j to the XOR of every position with bit j set.
    function automatic logic [CW_BITS-1:0] hamming_encode(input logic [CW_DATA_BITS-1:0] d);
        logic [CW_BITS-1:0] w;
        int unsigned        k;
        logic               par;
        w = '0;
        k = 0;
        for (int unsigned p = 1; p <= CW_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                w[p-1] = d[k];
                k++;
            end
        end
        for (int unsigned j = 0; j < PARITY_BITS; j++) begin
            par = 1'b0;
            for (int unsigned p = 1; p <= CW_BITS; p++) begin
                if ((p != (1 << j)) && ((p & (1 << j)) != 0)) begin
                    par = par ^ w[p-1];
                end
            end
            w[(1 << j) - 1] = par;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ham_enc_ram.sv */
`default_nettype none

module ham_enc_ram #(
    parameter int unsigned WIDTH = ham_enc_pkg::BYTE_W,
    parameter int unsigned DEPTH = ham_enc_pkg::DATA_BYTES,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/hamming_63_57_block_encoder.sv */
// After the 57th data byte is taken, the block store is read back into a bit accumulator,
// each 57 data bits are encoded into a codeword in the output bit buffer, and the 63
// code bytes leave one at a time through the one-byte output register. Input is held
// off until the last code byte of the block has moved into that register, so a new
// block is not taken before the current one has been encoded.
// Reset: aresetn is synchronous, active low; it drops a partial block and any
// undelivered code bytes. The block store itself is not cleared.
`default_nettype none

module hamming_63_57_block_encoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input channel
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    // result channel
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] code_byte
    output logic            m_tlast    // last_of_block
);

    localparam int unsigned BW   = ham_enc_pkg::BYTE_W;
    localparam int unsigned FW   = ham_enc_pkg::FILL_W;
    localparam int unsigned OW   = ham_enc_pkg::OCNT_W;
    localparam int unsigned AW   = ham_enc_pkg::ACNT_W;
    localparam int unsigned OCW  = ham_enc_pkg::OBCW;
    localparam int unsigned ACCW = ham_enc_pkg::ACC_W;
    localparam int unsigned OBW  = ham_enc_pkg::OBUF_W;
    localparam int unsigned CWB  = ham_enc_pkg::CW_BITS;
    localparam int unsigned CWD  = ham_enc_pkg::CW_DATA_BITS;

    localparam logic [FW-1:0]  LAST_FILL = FW'(ham_enc_pkg::DATA_BYTES - 1);
    localparam logic [FW-1:0]  NUM_BYTES = FW'(ham_enc_pkg::DATA_BYTES);
    localparam logic [OW-1:0]  LAST_OUT  = OW'(ham_enc_pkg::CODE_BYTES - 1);
    localparam logic [AW-1:0]  CWD_CNT   = AW'(CWD);
    localparam logic [AW-1:0]  BYTE_ACNT = AW'(BW);
    localparam logic [OCW-1:0] BYTE_OCNT = OCW'(BW);
    localparam logic [OCW-1:0] CWB_CNT   = OCW'(CWB);

    ham_enc_pkg::phase_t phase_reg, phase_next;

    logic [FW-1:0]   fill_reg, fill_next;        // bytes collected in this block
    logic [FW-1:0]   rd_addr_reg, rd_addr_next;  // next store entry to read
    logic            rd_pend_reg, rd_pend_next;  // read data arrives this cycle
    logic [ACCW-1:0] acc_reg, acc_next;          // unread data bits, LSB first
    logic [AW-1:0]   acnt_reg, acnt_next;
    logic [OBW-1:0]  obuf_reg, obuf_next;        // coded bits not yet sent
    logic [OCW-1:0]  ocnt_reg, ocnt_next;
    logic [OW-1:0]   ocount_reg, ocount_next;    // code bytes sent in this block
    logic            m_tvalid_reg, m_tvalid_next;
    logic [BW-1:0]   m_tdata_reg, m_tdata_next;
    logic            m_tlast_reg, m_tlast_next;

    logic          s_fire;
    logic          rd_issue;
    logic          cw_load;
    logic          emit;
    logic [BW-1:0] rd_data;
    logic [CWB-1:0] codeword;
    logic [AW-1:0] acnt_ahead;

    // Block store: written only while collecting, read only while encoding,
    // so a write and a read never meet on one entry.
    ham_enc_ram #(
        .WIDTH (BW),
        .DEPTH (ham_enc_pkg::DATA_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_fire),
        .wr_addr (fill_reg),
        .wr_data (s_tdata),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    assign s_fire = s_tvalid && s_tready;

    // Count a read in flight so the accumulator never overflows.
    assign acnt_ahead = acnt_reg + (rd_pend_reg ? BYTE_ACNT : '0);
    assign rd_issue   = (phase_reg == ham_enc_pkg::PH_ENCODE) && (rd_addr_reg < NUM_BYTES)
                        && (acnt_ahead < CWD_CNT);

    // Encode once 57 bits wait and the output buffer has room for a codeword.
    assign cw_load  = (acnt_reg >= CWD_CNT) && (ocnt_reg < BYTE_OCNT);
    assign codeword = ham_enc_pkg::hamming_encode(acc_reg[CWD-1:0]);

    // Move one code byte into the output register when it is free.
    assign emit = (ocnt_reg >= BYTE_OCNT) && (!m_tvalid_reg || m_tready);

    // next state
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            ham_enc_pkg::PH_COLLECT: begin
                if (s_fire && (fill_reg == LAST_FILL)) begin
                    phase_next = ham_enc_pkg::PH_ENCODE;
                end
            end
            ham_enc_pkg::PH_ENCODE: begin
                if (emit && (ocount_reg == LAST_OUT)) begin
                    phase_next = ham_enc_pkg::PH_COLLECT;
                end
            end
            default: phase_next = ham_enc_pkg::PH_COLLECT;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_tready = 1'b0;
        case (phase_reg)
            ham_enc_pkg::PH_COLLECT: s_tready = 1'b1;
            ham_enc_pkg::PH_ENCODE:  s_tready = 1'b0;
            default:                 s_tready = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        fill_next     = fill_reg;
        rd_addr_next  = rd_addr_reg;
        rd_pend_next  = rd_issue;
        acc_next      = acc_reg;
        acnt_next     = acnt_reg;
        obuf_next     = obuf_reg;
        ocnt_next     = ocnt_reg;
        ocount_next   = ocount_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (s_fire) begin
            fill_next = (fill_reg == LAST_FILL) ? '0 : fill_reg + 1'b1;
        end

        if (rd_issue) begin
            rd_addr_next = rd_addr_reg + 1'b1;
        end

        // append the returned byte above the held bits
        if (rd_pend_reg) begin
            acc_next  = acc_reg | (ACCW'(rd_data) << acnt_reg);
            acnt_next = acnt_reg + BYTE_ACNT;
        end

        // consume one codeword of data bits
        if (cw_load) begin
            acc_next  = acc_reg >> CWD;
            acnt_next = acnt_reg - CWD_CNT;
            obuf_next = obuf_reg | (OBW'(codeword) << ocnt_reg);
            ocnt_next = ocnt_reg + CWB_CNT;
        end

        if (emit) begin
            obuf_next     = obuf_reg >> BW;
            ocnt_next     = ocnt_reg - BYTE_OCNT;
            m_tvalid_next = 1'b1;
            m_tdata_next  = obuf_reg[BW-1:0];
            m_tlast_next  = (ocount_reg == LAST_OUT);
            if (ocount_reg == LAST_OUT) begin
                ocount_next  = '0;
                rd_addr_next = '0;
            end else begin
                ocount_next = ocount_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= ham_enc_pkg::PH_COLLECT;
            fill_reg     <= '0;
            rd_addr_reg  <= '0;
            rd_pend_reg  <= 1'b0;
            acc_reg      <= '0;
            acnt_reg     <= '0;
            obuf_reg     <= '0;
            ocnt_reg     <= '0;
            ocount_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            rd_addr_reg  <= rd_addr_next;
            rd_pend_reg  <= rd_pend_next;
            acc_reg      <= acc_next;
            acnt_reg     <= acnt_next;
            obuf_reg     <= obuf_next;
            ocnt_reg     <= ocnt_next;
            ocount_reg   <= ocount_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload of the output register
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // read data only returns while the accumulator has room for it
    a_rd_room: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (acnt_reg < CWD_CNT))
        else $error("read data returned into a full accumulator");

    // after the last code byte every data and code bit has been used
    a_block_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (ocount_reg == LAST_OUT)) |=> ((ocnt_reg == '0) && (acnt_reg == '0)
            && (rd_addr_reg == '0)))
        else $error("bit buffers not empty at end of block");

    // a codeword is never loaded while a byte is being emitted
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cw_load && emit))
        else $error("codeword load collided with byte emit");

    // no input is taken while the block is being encoded
    a_fill_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == ham_enc_pkg::PH_ENCODE) |-> (fill_reg == '0))
        else $error("fill count moved during encoding");
`endif

endmodule

`default_nettype wire

/* verif/hamming_63_57_block_encoder_tb.sv */
`default_nettype none

module hamming_63_57_block_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ham_enc_pkg::*;

    localparam int unsigned CODEWORDS   = 8;
    localparam int unsigned STREAM_BITS = DATA_BYTES * BYTE_W;   // 456
    localparam int unsigned CODE_BITS   = CODE_BYTES * BYTE_W;   // 504
    localparam int unsigned MAX_GAP     = 6;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned HOLD_AFTER  = 70;     // code bytes seen before the long hold
    localparam int unsigned DRAIN_WAIT  = 40;     // watch time for spurious output after the last code byte
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RAND_BLOCKS = 7;

    typedef enum int unsigned {
        FILL_RANDOM,
        FILL_SPARSE,
        FILL_DENSE,
        FILL_EXTREME
    } fill_kind_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_of_block;
    } code_beat_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] code_byte
    logic       m_tlast;            // last_of_block

    hamming_63_57_block_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // data bytes waiting to be offered, and code bytes the encoder still owes
    logic [7:0]        pending_bytes[$];
    code_beat_t        owed_code_bytes[$];

    // predictor state: the block being collected and how far it is filled
    logic [STREAM_BITS-1:0] held_stream = '0;
    int unsigned            held_count  = 0;

    int unsigned total_bytes  = 0;
    int unsigned bytes_in     = 0;
    int unsigned codes_seen   = 0;
    int unsigned blocks_done  = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;

    logic        in_taken  = 1'b0;
    logic        out_taken = 1'b0;
    int unsigned tx_gap    = 0;
    logic        tx_burst  = 1'b0;
    int unsigned rx_wait   = 0;
    int unsigned rx_wait_now;
    logic        rx_burst  = 1'b0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    // Build one codeword: data bits go to the positions that are not powers of
    // two; the XOR of the positions of all set data bits gives the six parity
    // bits at once, bit j of it landing at position 2^j.
    function automatic logic [CW_BITS-1:0] build_codeword(input logic [CW_DATA_BITS-1:0] piece);
        logic [CW_BITS-1:0] word;
        logic [5:0]         syndrome;
        int unsigned        k;
        word     = '0;
        syndrome = '0;
        k        = 0;
        for (int unsigned pos = 1; pos <= CW_BITS; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
                word[pos-1] = piece[k];
                if (piece[k]) begin
                    syndrome = syndrome ^ 6'(pos);
                end
                k++;
            end
        end
        for (int unsigned j = 0; j < PARITY_BITS; j++) begin
            word[(1 << j) - 1] = syndrome[j];
        end
        return word;
    endfunction

    // Add one accepted data byte; on the 57th byte, queue the 63 code bytes.
    task automatic collect_byte(input logic [7:0] data_byte);
        logic [CODE_BITS-1:0] code_stream;
        code_beat_t           beat;
        held_stream[held_count*BYTE_W +: BYTE_W] = data_byte;
        held_count++;
        if (held_count == DATA_BYTES) begin
            held_count = 0;
            for (int unsigned cw = 0; cw < CODEWORDS; cw++) begin
                code_stream[cw*CW_BITS +: CW_BITS] =
                    build_codeword(held_stream[cw*CW_DATA_BITS +: CW_DATA_BITS]);
            end
            for (int unsigned b = 0; b < CODE_BYTES; b++) begin
                beat.code_byte     = code_stream[b*BYTE_W +: BYTE_W];
                beat.last_of_block = (b == CODE_BYTES - 1);
                owed_code_bytes.push_back(beat);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < 50) begin
            $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h (code byte %0d)",
                     $realtime, what, got, want, codes_seen);
        end
        error_count++;
    endtask

    function automatic logic [7:0] fill_byte(input fill_kind_t kind);
        logic [7:0] one_hot;
        one_hot = 8'h01 << $urandom_range(0, 7);
        case (kind)
            FILL_SPARSE: begin
                return ($urandom_range(0, 7) == 0) ? one_hot : 8'h00;
            end
            FILL_DENSE: begin
                return ($urandom_range(0, 7) == 0) ? ~one_hot : 8'hFF;
            end
            FILL_EXTREME: begin
                return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    // Sample both channels at the rising edge; check before predicting so a
    // code byte is never compared with bytes queued in the same cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                if (owed_code_bytes.size() == 0) begin
                    report_mismatch("unexpected code byte", m_tdata, 0);
                end else begin
                    code_beat_t want;
                    want = owed_code_bytes.pop_front();
                    if (m_tdata !== want.code_byte) begin
                        report_mismatch("code_byte", m_tdata, want.code_byte);
                    end
                    if (m_tlast !== want.last_of_block) begin
                        report_mismatch("last_of_block", m_tlast, want.last_of_block);
                    end
                    if (want.last_of_block) begin
                        blocks_done++;
                    end
                end
                codes_seen++;
            end
            if (s_tvalid && s_tready) begin
                collect_byte(s_tdata);
                bytes_in++;
            end
        end
    end

    // Sender: hold the current transaction until accepted, then idle for the
    // drawn gap before offering the next byte. Bursts switch the gaps off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= $urandom_range(0, MAX_GAP);
        end else if (!s_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes.pop_front();
                tx_gap   <= tx_burst ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 39) == 0) begin
                    tx_burst <= !tx_burst;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long back-pressure: once the second block is on its way out, drop
    // m_tready for a long stretch so the encoder fills up and stalls s_tready.
    always @(negedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && codes_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: after each accepted code byte, stall for the drawn count.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else begin
            if (out_taken) begin
                rx_wait_now = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 39) == 0) begin
                    rx_burst <= !rx_burst;
                end
            end else if (rx_wait > 0) begin
                rx_wait_now = rx_wait - 1;
            end else begin
                rx_wait_now = 0;
            end
            rx_wait  <= rx_wait_now;
            m_tready <= (rx_wait_now == 0) && (hold_left == 0);
        end
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d code bytes still owed",
                     cycle_count, owed_code_bytes.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        fill_kind_t  kind;
        int unsigned tail_len;

        // Directed opening: field extremes, every single bit, alternating
        // patterns; the rest of the first block is random.
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        for (int unsigned i = 0; i < BYTE_W; i++) begin
            pending_bytes.push_back(8'h01 << i);
        end
        pending_bytes.push_back(8'hAA);
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'hFE);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        while (pending_bytes.size() < DATA_BYTES) begin
            pending_bytes.push_back(8'($urandom));
        end

        // Random blocks, each with a content style drawn per block so that
        // sparse and dense codewords exercise every parity bit.
        for (int unsigned blk = 0; blk < RAND_BLOCKS; blk++) begin
            kind = fill_kind_t'($urandom_range(0, 3));
            for (int unsigned i = 0; i < DATA_BYTES; i++) begin
                pending_bytes.push_back(fill_byte(kind));
            end
        end

        // Partial block at the end: it must never come out.
        tail_len = $urandom_range(5, 30);
        for (int unsigned i = 0; i < tail_len; i++) begin
            pending_bytes.push_back(8'($urandom));
        end
        total_bytes = pending_bytes.size();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every byte to be taken and every code byte to arrive, then
        // watch a while longer for anything spurious from the held tail.
        while (bytes_in < total_bytes) @(negedge aclk);
        while (owed_code_bytes.size() > 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("sent %0d data bytes (%0d full blocks, %0d-byte tail held back)",
                 bytes_in, bytes_in / DATA_BYTES, bytes_in % DATA_BYTES);
        $display("checked %0d code bytes in %0d blocks, %0d mismatches, long hold %s",
                 codes_seen, blocks_done, error_count, hold_done ? "applied" : "not reached");
        if (error_count == 0 && owed_code_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
